/* rtl/core/rpam_pkg.sv */
// ----------------------------------------------------------------------------
// rpam_pkg
// shared constants for the rotation pixel address map: default widths,
// register indexes and register reset values
// ----------------------------------------------------------------------------
package rpam_pkg;

    // default parameter values
    localparam int DIM_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF = 14;

    // byte offsets are always this wide
    localparam int OFF_BITS = 26;

    // configuration port
    localparam int CFG_ADDR_BITS = 3;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_COS        = 3'd4,
        REG_SIN        = 3'd5
    } cfg_reg_t;

    // register reset values
    localparam int RST_SRC_WIDTH  = 640;
    localparam int RST_SRC_HEIGHT = 480;
    localparam int RST_DST_WIDTH  = 794;
    localparam int RST_DST_HEIGHT = 735;
    localparam int RST_COS        = 14189;
    localparam int RST_SIN        = 8192;

endpackage

/* rtl/core/rotate_pixel_address_map.sv */
// ----------------------------------------------------------------------------
// rotate_pixel_address_map
// maps a destination pixel back through a rotation and gives byte offsets
// ----------------------------------------------------------------------------
// input items on s_*: one destination position (row, column) each.
// result items on m_*: in_range flag in tuser, source and destination byte
// offsets in tdata, for 24-bit pixels in rows padded to four bytes. the
// source offset is zero when the point falls outside the source image.
// registers (sizes, q-format cosine and sine) load through cfg_wr_en /
// cfg_addr / cfg_wr_data, one per clock; the user must write them only
// while no item is in flight, which the block does not enforce. six
// register stages: three in the rotation front end (centre, multiply,
// sum) and three in the offset back end (truncate and check, stride
// multiply, add). throughput is one item per clock while m_tready is high;
// every stage has its own valid bit and advances when empty or when the
// stage after it advances, so a stalled m_tready fills bubbles first and
// only then drops s_tready. reset clears all valid bits and loads the
// default registers: 640x480 source, 794x735 destination, 30 degrees.
// ----------------------------------------------------------------------------
module rotate_pixel_address_map #(
    parameter int DIM_BITS  = rpam_pkg::DIM_BITS_DEF,
    parameter int FRAC_BITS = rpam_pkg::FRAC_BITS_DEF,
    localparam int CW       = FRAC_BITS + 2,
    localparam int CFG_W    = (DIM_BITS > CW) ? DIM_BITS : CW,
    localparam int S_DATA_W = ((2 * DIM_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * rpam_pkg::OFF_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [rpam_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_W-1:0]                  cfg_wr_data,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [S_DATA_W-1:0]               s_tdata,   // dst_row, dst_col
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_DATA_W-1:0]               m_tdata,   // src_offset, dst_offset
    output logic [0:0]                        m_tuser    // in_range
);

    localparam int AW = DIM_BITS + FRAC_BITS + 4;
    localparam int SW = DIM_BITS + 2;
    localparam int OW = rpam_pkg::OFF_BITS;

    logic [DIM_BITS-1:0]  src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic signed [CW-1:0] cos_reg, sin_reg;

    logic [SW-1:0] src_stride_sum, dst_stride_sum;
    logic [SW-1:0] src_stride, dst_stride;

    logic                 mid_valid, mid_ready;
    logic signed [AW-1:0] mid_ax, mid_ay;
    logic [DIM_BITS-1:0]  mid_row, mid_col;

    logic                 res_in_range;
    logic [OW-1:0]        res_src_offset, res_dst_offset;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= DIM_BITS'(rpam_pkg::RST_SRC_WIDTH);
            src_height_reg <= DIM_BITS'(rpam_pkg::RST_SRC_HEIGHT);
            dst_width_reg  <= DIM_BITS'(rpam_pkg::RST_DST_WIDTH);
            dst_height_reg <= DIM_BITS'(rpam_pkg::RST_DST_HEIGHT);
            cos_reg        <= CW'(rpam_pkg::RST_COS);
            sin_reg        <= CW'(rpam_pkg::RST_SIN);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rpam_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_wr_data[DIM_BITS-1:0];
                rpam_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_wr_data[DIM_BITS-1:0];
                rpam_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_wr_data[DIM_BITS-1:0];
                rpam_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_wr_data[DIM_BITS-1:0];
                rpam_pkg::REG_COS:        cos_reg        <= $signed(cfg_wr_data[CW-1:0]);
                rpam_pkg::REG_SIN:        sin_reg        <= $signed(cfg_wr_data[CW-1:0]);
                default: ;
            endcase
        end
    end

    // row stride: 3*w rounded up to a multiple of 4
    assign src_stride_sum = SW'({src_width_reg, 1'b0}) + SW'(src_width_reg) + SW'(3);
    assign dst_stride_sum = SW'({dst_width_reg, 1'b0}) + SW'(dst_width_reg) + SW'(3);
    assign src_stride     = {src_stride_sum[SW-1:2], 2'b00};
    assign dst_stride     = {dst_stride_sum[SW-1:2], 2'b00};

    rpam_rotate #(
        .DIM_BITS  (DIM_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_rotate (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .dst_width  (dst_width_reg),
        .dst_height (dst_height_reg),
        .cos_coef   (cos_reg),
        .sin_coef   (sin_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_row     (s_tdata[DIM_BITS-1:0]),
        .in_col     (s_tdata[2*DIM_BITS-1:DIM_BITS]),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .out_ax     (mid_ax),
        .out_ay     (mid_ay),
        .out_row    (mid_row),
        .out_col    (mid_col)
    );

    rpam_offset #(
        .DIM_BITS  (DIM_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_offset (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .src_width      (src_width_reg),
        .src_height     (src_height_reg),
        .src_stride     (src_stride),
        .dst_stride     (dst_stride),
        .in_valid       (mid_valid),
        .in_ready       (mid_ready),
        .in_ax          (mid_ax),
        .in_ay          (mid_ay),
        .in_row         (mid_row),
        .in_col         (mid_col),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_in_range   (res_in_range),
        .out_src_offset (res_src_offset),
        .out_dst_offset (res_dst_offset)
    );

    assign m_tdata    = M_DATA_W'({res_dst_offset, res_src_offset});
    assign m_tuser[0] = res_in_range;

endmodule

/* rtl/core/rpam_rotate.sv */
// ----------------------------------------------------------------------------
// rpam_rotate
// three-stage front end: centre the destination position, form the four
// coefficient products, sum them with the source half size in fixed point
// ----------------------------------------------------------------------------
module rpam_rotate #(
    parameter int DIM_BITS  = rpam_pkg::DIM_BITS_DEF,
    parameter int FRAC_BITS = rpam_pkg::FRAC_BITS_DEF,
    localparam int CW = FRAC_BITS + 2,
    localparam int AW = DIM_BITS + FRAC_BITS + 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration, stable while items are in flight
    input  logic [DIM_BITS-1:0]  src_width,
    input  logic [DIM_BITS-1:0]  src_height,
    input  logic [DIM_BITS-1:0]  dst_width,
    input  logic [DIM_BITS-1:0]  dst_height,
    input  logic signed [CW-1:0] cos_coef,
    input  logic signed [CW-1:0] sin_coef,
    // upstream
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DIM_BITS-1:0]  in_row,
    input  logic [DIM_BITS-1:0]  in_col,
    // downstream
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [AW-1:0] out_ax,
    output logic signed [AW-1:0] out_ay,
    output logic [DIM_BITS-1:0]  out_row,
    output logic [DIM_BITS-1:0]  out_col
);

    localparam int XW = DIM_BITS + 1;
    localparam int PW = XW + CW;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // stage 1: centred position
    logic signed [XW-1:0] x_next, y_next;
    logic signed [XW-1:0] x_reg, y_reg;
    logic [DIM_BITS-1:0]  row1_reg, col1_reg;

    // stage 2: products
    logic signed [PW-1:0] xc_reg, xs_reg, yc_reg, ys_reg;
    logic [DIM_BITS-1:0]  row2_reg, col2_reg;

    // stage 3: fixed-point source position
    logic signed [AW-1:0] half_sw, half_sh;
    logic signed [AW-1:0] ax_next, ay_next;
    logic signed [AW-1:0] ax_reg, ay_reg;
    logic [DIM_BITS-1:0]  row3_reg, col3_reg;

    // a stage moves when it is empty or the next one moves
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign x_next = $signed({1'b0, in_col}) - $signed({2'b00, dst_width[DIM_BITS-1:1]});
    assign y_next = $signed({1'b0, in_row}) - $signed({2'b00, dst_height[DIM_BITS-1:1]});

    assign half_sw = AW'($signed({1'b0, src_width[DIM_BITS-1:1], {FRAC_BITS{1'b0}}}));
    assign half_sh = AW'($signed({1'b0, src_height[DIM_BITS-1:1], {FRAC_BITS{1'b0}}}));

    assign ax_next = AW'(xc_reg) - AW'(ys_reg) + half_sw;
    assign ay_next = AW'(xs_reg) + AW'(yc_reg) + half_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            row1_reg <= in_row;
            col1_reg <= in_col;
        end
        if (rdy2) begin
            xc_reg   <= PW'(x_reg) * PW'(cos_coef);
            xs_reg   <= PW'(x_reg) * PW'(sin_coef);
            yc_reg   <= PW'(y_reg) * PW'(cos_coef);
            ys_reg   <= PW'(y_reg) * PW'(sin_coef);
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
        end
        if (rdy3) begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_ax    = ax_reg;
    assign out_ay    = ay_reg;
    assign out_row   = row3_reg;
    assign out_col   = col3_reg;

endmodule

/* rtl/core/rpam_offset.sv */
// ----------------------------------------------------------------------------
// rpam_offset
// three-stage back end: truncate to whole source pixels and range check,
// multiply by the padded row strides, add the column bytes
// ----------------------------------------------------------------------------
module rpam_offset #(
    parameter int DIM_BITS  = rpam_pkg::DIM_BITS_DEF,
    parameter int FRAC_BITS = rpam_pkg::FRAC_BITS_DEF,
    localparam int AW = DIM_BITS + FRAC_BITS + 4,
    localparam int SW = DIM_BITS + 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [DIM_BITS-1:0]  src_width,
    input  logic [DIM_BITS-1:0]  src_height,
    input  logic [SW-1:0]        src_stride,
    input  logic [SW-1:0]        dst_stride,
    // upstream
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [AW-1:0] in_ax,
    input  logic signed [AW-1:0] in_ay,
    input  logic [DIM_BITS-1:0]  in_row,
    input  logic [DIM_BITS-1:0]  in_col,
    // downstream
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_in_range,
    output logic [rpam_pkg::OFF_BITS-1:0] out_src_offset,
    output logic [rpam_pkg::OFF_BITS-1:0] out_dst_offset
);

    localparam int OW    = rpam_pkg::OFF_BITS;
    localparam int PRW   = 2 * DIM_BITS + 3;
    localparam int EW    = (PRW > OW) ? PRW : OW;
    localparam int IW    = AW - FRAC_BITS;

    logic v4_reg, v5_reg, v6_reg;
    logic rdy4, rdy5, rdy6;

    // stage 4: truncation toward zero and range check
    logic signed [AW-1:0] ax_adj, ay_adj;
    logic [IW-1:0]        sx_full, sy_full;
    logic                 src_hit;
    logic                 in4_reg;
    logic [DIM_BITS-1:0]  sx_reg, sy_reg, row4_reg, col4_reg;

    // stage 5: partial terms
    logic                 in5_reg;
    logic [EW-1:0]        sp_reg, sc_reg, dp_reg, dc_reg;

    // stage 6: offsets
    logic [EW-1:0]        soff_sum, doff_sum;
    logic                 in6_reg;
    logic [OW-1:0]        soff_reg, doff_reg;

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    // negative values get all-ones fraction added so the shift rounds toward zero
    assign ax_adj = in_ax + (in_ax[AW-1] ? AW'({FRAC_BITS{1'b1}}) : AW'(0));
    assign ay_adj = in_ay + (in_ay[AW-1] ? AW'({FRAC_BITS{1'b1}}) : AW'(0));
    assign sx_full = ax_adj[AW-1:FRAC_BITS];
    assign sy_full = ay_adj[AW-1:FRAC_BITS];

    assign src_hit = !sx_full[IW-1] && !sy_full[IW-1]
                  && (sx_full[IW-2:0] < (IW-1)'(src_width))
                  && (sy_full[IW-2:0] < (IW-1)'(src_height));

    assign soff_sum = sp_reg + sc_reg;
    assign doff_sum = dp_reg + dc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy4) begin
                v4_reg <= in_valid;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (rdy6) begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            in4_reg  <= src_hit;
            // out-of-range points use coordinate zero so the offset comes out zero
            sx_reg   <= src_hit ? sx_full[DIM_BITS-1:0] : '0;
            sy_reg   <= src_hit ? sy_full[DIM_BITS-1:0] : '0;
            row4_reg <= in_row;
            col4_reg <= in_col;
        end
        if (rdy5) begin
            in5_reg <= in4_reg;
            sp_reg  <= EW'(src_stride) * EW'(sy_reg);
            sc_reg  <= EW'({sx_reg, 1'b0}) + EW'(sx_reg);
            dp_reg  <= EW'(dst_stride) * EW'(row4_reg);
            dc_reg  <= EW'({col4_reg, 1'b0}) + EW'(col4_reg);
        end
        if (rdy6) begin
            in6_reg  <= in5_reg;
            soff_reg <= soff_sum[OW-1:0];
            doff_reg <= doff_sum[OW-1:0];
        end
    end

    assign out_valid      = v6_reg;
    assign out_in_range   = in6_reg;
    assign out_src_offset = soff_reg;
    assign out_dst_offset = doff_reg;

endmodule

/* rtl/core/rpam_check.sv */
// ----------------------------------------------------------------------------
// rpam_check
// port-level checks on the rotation address map, bound to the top level
// ----------------------------------------------------------------------------
module rpam_check #(
    parameter int DIM_BITS  = rpam_pkg::DIM_BITS_DEF,
    parameter int FRAC_BITS = rpam_pkg::FRAC_BITS_DEF,
    localparam int CW       = FRAC_BITS + 2,
    localparam int CFG_W    = (DIM_BITS > CW) ? DIM_BITS : CW,
    localparam int S_DATA_W = ((2 * DIM_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * rpam_pkg::OFF_BITS + 7) / 8) * 8
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_wr_en,
    input logic [rpam_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input logic [CFG_W-1:0]                   cfg_wr_data,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [S_DATA_W-1:0]                s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [M_DATA_W-1:0]                m_tdata,
    input logic [0:0]                         m_tuser
);

    localparam int OW = rpam_pkg::OFF_BITS;

    // a stalled result item stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // and its payload does not change
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // points outside the source image carry a zero source offset
    a_out_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[OW-1:0] == '0)
        else $error("nonzero source offset for out-of-range point");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item offered right after reset");

endmodule

bind rotate_pixel_address_map rpam_check #(
    .DIM_BITS  (DIM_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_rpam_check (.*);
